// ===== src/tdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsm_pkg
// Shared types and constants of the trial-division survivor mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdsm_pkg;

   localparam int unsigned MAX_BATCH_DEF   = 64;
   localparam int unsigned PRIME_COUNT_DEF = 30;
   localparam int unsigned NIB_COUNT       = 16;
   localparam int unsigned RES_W           = 7;

   localparam logic [RES_W-1:0] PRIMES [30] = '{
      7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29, 7'd31,
      7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73,
      7'd79, 7'd83, 7'd89, 7'd97, 7'd101, 7'd103, 7'd107, 7'd109, 7'd113, 7'd127
   };

   localparam int unsigned ROOT_DELTA_STEP = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_PREP,
      ST_LOAD,
      ST_WALK,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   // token passed from cell to cell, one per cycle
   typedef struct packed {
      logic        first;
      logic        load;
      logic        step;
      logic        done;
      logic [3:0]  cand_nib;
      logic [3:0]  delta_nib;
      logic [63:0] cand;
      logic        cand_wrap;
      logic        delta_wrap;
      logic        kill;
   } link_type;

endpackage

`default_nettype wire

// ===== src/tdsm_if.sv =====
// ----------------------------------------------------------------------------
// tdsm_req_if / tdsm_rsp_if
// Valid/ready channels for the request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdsm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] big_n;
   logic [31:0] first_root;
   logic [6:0]  batch_count;

   modport source (output valid, big_n, first_root, batch_count, input ready);
   modport sink   (input valid, big_n, first_root, batch_count, output ready);
endinterface

interface tdsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] survivor_mask;

   modport source (output valid, survivor_mask, input ready);
   modport sink   (input valid, survivor_mask, output ready);
endinterface

`default_nettype wire

// ===== src/tdsm_cell.sv =====
// ----------------------------------------------------------------------------
// tdsm_cell
// One trial prime: tracks the candidate and step residues and marks hits.
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_cell #(
   parameter logic [tdsm_pkg::RES_W-1:0] PRIME = 7'd3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tdsm_pkg::link_type link_in,
   output tdsm_pkg::link_type     link_out
);

   localparam int unsigned W = tdsm_pkg::RES_W;
   localparam logic [W-1:0] STEP_RES = W'(tdsm_pkg::ROOT_DELTA_STEP % PRIME);
   // residue of 2^64, removed or added back when a 64-bit sum wraps
   localparam longint unsigned R32 = (64'd1 << 32) % 64'(PRIME);
   localparam logic [W-1:0] WRAP_RES = W'((R32 * R32) % 64'(PRIME));

   logic [W-1:0]      rc_ff, rc_in;
   logic [W-1:0]      rd_ff, rd_in;
   tdsm_pkg::link_type link_ff, link_in_nx;

   function automatic logic [W-1:0] fold(input logic [W-1:0] r, input logic [3:0] nib);
      logic [W+3:0] x;
      x = {r, nib};
      for (int b = 3; b >= 0; b--) begin
         if (x >= ((W+4)'(PRIME) << b)) begin
            x = x - ((W+4)'(PRIME) << b);
         end
      end
      return x[W-1:0];
   endfunction

   logic [W:0]   sum;
   logic [W-1:0] rc_sum;
   logic [W-1:0] rd_dec;
   logic [W:0]   rd_fix;

   always_comb begin
      rc_in      = rc_ff;
      rd_in      = rd_ff;
      link_in_nx = link_in;
      sum        = {1'b0, rc_ff} + {1'b0, rd_ff};
      rc_sum     = (sum >= {1'b0, PRIME}) ? W'(sum - {1'b0, PRIME}) : sum[W-1:0];
      rd_dec     = (rd_ff >= STEP_RES) ? rd_ff - STEP_RES : rd_ff + (PRIME - STEP_RES);
      rd_fix     = {1'b0, rd_dec} + {1'b0, WRAP_RES};
      if (link_in.load) begin
         rc_in = fold(link_in.first ? '0 : rc_ff, link_in.cand_nib);
         rd_in = fold(link_in.first ? '0 : rd_ff, link_in.delta_nib);
      end
      if (link_in.step) begin
         if (rc_ff == '0 && link_in.cand != 64'(PRIME)) begin
            link_in_nx.kill = 1'b1;
         end
         if (link_in.cand_wrap) begin
            rc_in = (rc_sum >= WRAP_RES) ? rc_sum - WRAP_RES : rc_sum + (PRIME - WRAP_RES);
         end else begin
            rc_in = rc_sum;
         end
         if (link_in.delta_wrap) begin
            rd_in = (rd_fix >= {1'b0, PRIME}) ? W'(rd_fix - {1'b0, PRIME}) : rd_fix[W-1:0];
         end else begin
            rd_in = rd_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rc_ff <= rc_in;
      rd_ff <= rd_in;
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_nx;
      end
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

// ===== src/tdsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdsm_ctrl
// Sequencer: squares the root, feeds residue nibbles, then walks candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_ctrl #(
   parameter int unsigned MAX_BATCH = tdsm_pkg::MAX_BATCH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   tdsm_req_if.sink                 req_ch,
   input  wire logic                rsp_fire,
   output tdsm_pkg::link_type       link_out,
   output logic [63:0]              kmask,
   output tdsm_pkg::state_type      state
);

   tdsm_pkg::state_type state_ff, state_in;
   logic [63:0] n_ff, n_in;
   logic [31:0] root_ff, root_in;
   logic [6:0]  k_ff, k_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] cand_ff, cand_in;
   logic [63:0] delta_ff, delta_in;
   logic [63:0] csh_ff, csh_in;
   logic [63:0] dsh_ff, dsh_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  steps_ff, steps_in;
   logic [63:0] kmask_ff, kmask_in;

   logic        req_fire;
   logic [63:0] cand_new;
   logic [63:0] delta_new;
   logic [64:0] cand_sum;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign cand_new  = (n_ff - sq_ff) >> 1;
   assign delta_new = ({32'b0, root_ff} - 64'd1) << 1;
   assign cand_sum  = {1'b0, cand_ff} + {1'b0, delta_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdsm_pkg::ST_IDLE:   if (req_fire) state_in = tdsm_pkg::ST_SQUARE;
         tdsm_pkg::ST_SQUARE: state_in = tdsm_pkg::ST_PREP;
         tdsm_pkg::ST_PREP:   state_in = tdsm_pkg::ST_LOAD;
         tdsm_pkg::ST_LOAD: begin
            if (cnt_ff == 7'(tdsm_pkg::NIB_COUNT - 1)) state_in = tdsm_pkg::ST_WALK;
         end
         tdsm_pkg::ST_WALK: begin
            if (cnt_ff == steps_ff) state_in = tdsm_pkg::ST_FLUSH;
         end
         tdsm_pkg::ST_FLUSH:  state_in = tdsm_pkg::ST_HOLD;
         tdsm_pkg::ST_HOLD:   if (rsp_fire) state_in = tdsm_pkg::ST_IDLE;
         default:             state_in = tdsm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      link_out          = '0;
      link_out.cand_nib = csh_ff[63:60];
      link_out.delta_nib = dsh_ff[63:60];
      link_out.cand     = cand_ff;
      link_out.kill     = (cand_ff < 64'd2);
      unique case (state_ff)
         tdsm_pkg::ST_LOAD: begin
            link_out.load  = 1'b1;
            link_out.first = (cnt_ff == '0);
         end
         tdsm_pkg::ST_WALK: begin
            link_out.step       = (cnt_ff != steps_ff);
            // 64-bit wrap of the next candidate and of the next step
            link_out.cand_wrap  = cand_sum[64];
            link_out.delta_wrap = (delta_ff < 64'(tdsm_pkg::ROOT_DELTA_STEP));
         end
         tdsm_pkg::ST_FLUSH: link_out.done = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      n_in     = n_ff;
      root_in  = root_ff;
      k_in     = k_ff;
      sq_in    = sq_ff;
      cand_in  = cand_ff;
      delta_in = delta_ff;
      csh_in   = csh_ff;
      dsh_in   = dsh_ff;
      cnt_in   = cnt_ff;
      steps_in = steps_ff;
      kmask_in = kmask_ff;
      case (state_ff)
         tdsm_pkg::ST_IDLE: begin
            n_in    = req_ch.big_n;
            root_in = req_ch.first_root;
            k_in    = (req_ch.batch_count > 7'(MAX_BATCH)) ? 7'(MAX_BATCH)
                                                           : req_ch.batch_count;
         end
         tdsm_pkg::ST_SQUARE: begin
            sq_in    = 64'(root_ff) * 64'(root_ff);
            kmask_in = (k_ff >= 7'd64) ? '1 : ((64'd1 << k_ff[5:0]) - 64'd1);
         end
         tdsm_pkg::ST_PREP: begin
            cand_in  = cand_new;
            csh_in   = cand_new;
            delta_in = delta_new;
            dsh_in   = delta_new;
            cnt_in   = '0;
            // an even root stops the walk once it reaches zero
            if (root_ff[0] || ({1'b0, root_ff[31:1]} >= 32'(k_ff))) begin
               steps_in = k_ff;
            end else begin
               steps_in = root_ff[7:1];
            end
         end
         tdsm_pkg::ST_LOAD: begin
            csh_in = csh_ff << 4;
            dsh_in = dsh_ff << 4;
            cnt_in = (cnt_ff == 7'(tdsm_pkg::NIB_COUNT - 1)) ? '0 : cnt_ff + 7'd1;
         end
         tdsm_pkg::ST_WALK: begin
            if (cnt_ff != steps_ff) begin
               cand_in  = cand_sum[63:0];
               delta_in = delta_ff - 64'(tdsm_pkg::ROOT_DELTA_STEP);
               cnt_in   = cnt_ff + 7'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_in_reg: begin
         n_ff     <= n_in;
         root_ff  <= root_in;
         k_ff     <= k_in;
         sq_ff    <= sq_in;
         cand_ff  <= cand_in;
         delta_ff <= delta_in;
         csh_ff   <= csh_in;
         dsh_ff   <= dsh_in;
         cnt_ff   <= cnt_in;
         steps_ff <= steps_in;
         kmask_ff <= kmask_in;
      end
      if (reset) begin
         state_ff <= tdsm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ch.ready = (state_ff == tdsm_pkg::ST_IDLE);
   assign kmask        = kmask_ff;
   assign state        = state_ff;

endmodule

`default_nettype wire

// ===== src/tdsm_collect.sv =====
// ----------------------------------------------------------------------------
// tdsm_collect
// Gathers the per-index verdicts leaving the chain into the response mask.
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_collect (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tdsm_pkg::link_type link_in,
   input  wire logic [63:0]    kmask,
   tdsm_rsp_if.source          rsp_ch
);

   logic [5:0]  idx_ff, idx_in;
   logic [63:0] mask_ff, mask_in;
   logic [63:0] out_ff, out_in;
   logic        valid_ff, valid_in;

   always_comb begin
      idx_in   = idx_ff;
      mask_in  = mask_ff;
      out_in   = out_ff;
      valid_in = valid_ff;
      if (rsp_ch.valid && rsp_ch.ready) begin
         valid_in = 1'b0;
      end
      if (link_in.first) begin
         idx_in  = '0;
         mask_in = '1;
      end
      if (link_in.step) begin
         if (link_in.kill) begin
            mask_in[idx_ff] = 1'b0;
         end
         idx_in = idx_ff + 6'd1;
      end
      if (link_in.done) begin
         out_in   = mask_ff & kmask;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      mask_ff <= mask_in;
      out_ff  <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.survivor_mask = out_ff;

endmodule

`default_nettype wire

// ===== src/trial_division_survivor_mask.sv =====
// ----------------------------------------------------------------------------
// trial_division_survivor_mask
// Batched trial-division sieve over a walk of candidates (N - a_i^2)/2.
// ----------------------------------------------------------------------------
// One transaction at a time. After a request is taken the block squares the
// root, prepares the first candidate and step, loads residues a nibble per
// cycle into the chain of prime cells, then walks the candidates (walked
// count up to the batch count), closes the walk with a final walk state that
// walks nothing, and sends the end token. Once the end token has rippled
// through the cell chain the response is valid, and the next request is
// taken once the response is consumed.
`default_nettype none

module trial_division_survivor_mask #(
   parameter int unsigned MAX_BATCH   = tdsm_pkg::MAX_BATCH_DEF,
   parameter int unsigned PRIME_COUNT = tdsm_pkg::PRIME_COUNT_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   tdsm_req_if.sink     req_ch,
   tdsm_rsp_if.source   rsp_ch
);

   tdsm_pkg::link_type  links [PRIME_COUNT+1];
   logic [63:0]         kmask;
   tdsm_pkg::state_type state;
   logic                rsp_fire;

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   tdsm_ctrl #(.MAX_BATCH(MAX_BATCH)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_fire (rsp_fire),
      .link_out (links[0]),
      .kmask    (kmask),
      .state    (state)
   );

   for (genvar g = 0; g < PRIME_COUNT; g++) begin : g_cell
      tdsm_cell #(.PRIME(tdsm_pkg::PRIMES[g])) u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (links[g]),
         .link_out (links[g+1])
      );
   end

   tdsm_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .link_in (links[PRIME_COUNT]),
      .kmask   (kmask),
      .rsp_ch  (rsp_ch)
   );

   // a response only appears while the sequencer holds its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> state == tdsm_pkg::ST_HOLD)
      else $error("response outside hold");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state == tdsm_pkg::ST_SQUARE)
      else $error("request not started");

   assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> !rsp_ch.valid && state == tdsm_pkg::ST_IDLE)
      else $error("response not retired");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({links[0].load, links[0].step, links[0].done}))
      else $error("chain token overlap");

endmodule

`default_nettype wire
